>>> rtl/core/byte_sequence_patcher_core_defines.svh
// ----------------------------------------------------------------------------
// Byte sequence patcher assertion macros
// Shared property shorthands; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef BYTE_SEQUENCE_PATCHER_CORE_DEFINES_SVH
`define BYTE_SEQUENCE_PATCHER_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define BSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define BSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Widths, register codes and shared structs of the byte sequence patcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsp_pkg;

  localparam int WinBytes = 8;
  localparam int IdxW     = $clog2(WinBytes);
  localparam int ByteW    = 8;
  localparam int LenW     = 4;
  localparam int OffW     = 3;
  localparam int PatW     = 64;
  localparam int CountW   = 21;
  localparam int LimitW   = 22;
  localparam int MDataW   = 32;
  localparam int PaddrW   = 6;
  localparam int PdataW   = 64;

  localparam logic [CountW-1:0] MaxBytes = CountW'(1048576);

  typedef enum logic [2:0] {
    REG_FIND_PATTERN = 3'd0,
    REG_MATCH_LEN    = 3'd1,
    REG_PATCH_BYTES  = 3'd2,
    REG_PATCH_LENGTH = 3'd3,
    REG_PATCH_OFFSET = 3'd4,
    REG_PLACE_LIMIT  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [PatW-1:0]   find_pattern;
    logic [LenW-1:0]   match_len;
    logic [PatW-1:0]   patch_bytes;
    logic [LenW-1:0]   patch_length;
    logic [OffW-1:0]   patch_offset;
    logic [LimitW-1:0] place_limit;
  } cfg_t;

  // Per-transaction control handed to the counter block.
  typedef struct packed {
    logic step;
    logic cmd;
    logic fin;
    logic hit;
  } step_t;

  // Counter block status back to the top level.
  typedef struct packed {
    logic              check_en;
    logic              patch_go;
    logic [CountW-1:0] report;
  } tally_t;

endpackage

>>> rtl/core/bsp_cell.sv
// ----------------------------------------------------------------------------
// bsp_cell
// One window slot: compare against its sequence byte, patch, hand on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsp_cell (
  input  logic                           clk,
  input  logic [bsp_pkg::IdxW-1:0]       age,
  input  logic                           shift,
  input  logic [bsp_pkg::ByteW-1:0]      byte_in,
  input  bsp_pkg::cfg_t                  cfg,
  input  logic                           patch_go,
  output logic                           match,
  output logic [bsp_pkg::ByteW-1:0]      byte_fwd,
  output logic [bsp_pkg::ByteW-1:0]      byte_q
);

  logic [bsp_pkg::LenW-1:0] age_w;
  logic                     cmp_on;
  logic [bsp_pkg::LenW-1:0] exp_pos;
  logic [2:0]               exp_idx;
  logic [bsp_pkg::ByteW-1:0] expected;
  logic [bsp_pkg::LenW-1:0] seat;
  logic [bsp_pkg::LenW:0]   seat_end;
  logic                     in_rng;
  logic [bsp_pkg::LenW-1:0] pat_pos;
  logic [2:0]               pat_idx;

  assign age_w    = bsp_pkg::LenW'(age);
  assign cmp_on   = age_w < cfg.match_len;
  // newest byte lines up with the last sequence byte
  assign exp_pos  = cfg.match_len - bsp_pkg::LenW'(1) - age_w;
  assign exp_idx  = exp_pos[2:0];
  assign expected = cfg.find_pattern[{exp_idx, 3'b000} +: bsp_pkg::ByteW];
  assign match    = !cmp_on || (byte_in == expected);

  assign seat     = bsp_pkg::LenW'(cfg.patch_offset) + age_w;
  assign seat_end = {1'b0, seat} + {1'b0, cfg.patch_length};
  assign in_rng   = (seat < cfg.match_len) && ({1'b0, cfg.match_len} <= seat_end);
  assign pat_pos  = cfg.match_len - bsp_pkg::LenW'(1) - seat;
  assign pat_idx  = pat_pos[2:0];

  assign byte_fwd = (patch_go && in_rng) ?
                    cfg.patch_bytes[{pat_idx, 3'b000} +: bsp_pkg::ByteW] : byte_in;

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_q <= byte_fwd;
    end
  end

endmodule

>>> rtl/core/bsp_tally.sv
// ----------------------------------------------------------------------------
// bsp_tally
// Overlap guard, found/skip/patched counters and the place limit check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsp_tally (
  input  logic                           clk,
  input  logic                           rst,
  input  bsp_pkg::step_t                 ctl,
  input  logic [bsp_pkg::LenW-1:0]       match_len,
  input  logic [bsp_pkg::LimitW-1:0]     place_limit,
  output bsp_pkg::tally_t                st
);

  logic [bsp_pkg::IdxW-1:0]   guard;
  logic [bsp_pkg::CountW-1:0] found;
  logic [bsp_pkg::CountW-1:0] skip;
  logic [bsp_pkg::CountW-1:0] patched;

  logic [bsp_pkg::IdxW-1:0]   guard_next;
  logic [bsp_pkg::CountW-1:0] found_next;
  logic [bsp_pkg::CountW-1:0] skip_next;
  logic [bsp_pkg::CountW-1:0] patched_next;
  logic [bsp_pkg::CountW-1:0] skip_load;
  logic                       under_limit;
  logic                       patch_go;
  logic signed [bsp_pkg::LimitW:0] rest;
  logic [bsp_pkg::LenW-1:0]   guard_load;

  assign under_limit = ($signed(place_limit) <= $signed(bsp_pkg::LimitW'(0))) ||
                       ($signed({1'b0, patched}) < $signed(place_limit));
  assign patch_go    = ctl.hit && ctl.cmd && (skip == '0) && under_limit;
  assign guard_load  = match_len - bsp_pkg::LenW'(1);

  always_comb begin
    found_next   = found;
    skip_next    = skip;
    patched_next = patched;
    if (ctl.hit && !ctl.cmd && (found < bsp_pkg::MaxBytes)) begin
      found_next = found + bsp_pkg::CountW'(1);
    end
    if (ctl.hit && ctl.cmd && (skip != '0)) begin
      skip_next = skip - bsp_pkg::CountW'(1);
    end
    if (patch_go && (patched < bsp_pkg::MaxBytes)) begin
      patched_next = patched + bsp_pkg::CountW'(1);
    end
  end

  // last N places: skip the first (total - N)
  assign rest      = $signed({2'b00, found_next}) +
                     $signed({place_limit[bsp_pkg::LimitW-1], place_limit});
  assign skip_load = ($signed(place_limit) < $signed(bsp_pkg::LimitW'(0)) &&
                      rest > $signed((bsp_pkg::LimitW + 1)'(0))) ?
                     rest[bsp_pkg::CountW-1:0] : '0;

  always_comb begin
    guard_next = guard;
    if (ctl.fin) begin
      guard_next = '0;
    end else if (ctl.hit) begin
      guard_next = guard_load[bsp_pkg::IdxW-1:0];
    end else if (guard != '0) begin
      guard_next = guard - bsp_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      guard   <= '0;
      found   <= '0;
      skip    <= '0;
      patched <= '0;
    end else if (ctl.step) begin
      guard <= guard_next;
      if (ctl.fin) begin
        found   <= '0;
        patched <= '0;
        skip    <= ctl.cmd ? '0 : skip_load;
      end else begin
        found   <= found_next;
        patched <= patched_next;
        skip    <= skip_next;
      end
    end
  end

  assign st.check_en = (guard == '0);
  assign st.patch_go = patch_go;
  assign st.report   = ctl.cmd ? patched_next : found_next;

endmodule

>>> rtl/core/byte_sequence_patcher_core.sv
// A patch-pass byte shifts through the window cells as later bytes are accepted, then leaves on m_tdata.
// Throughput: one byte per cycle while the output is taken and no drain runs, set by the eight-cell window.
// A final patch-pass byte holds s_tready low while the window drains.
// A final counting-pass byte gives its single result at its own acceptance edge.
// Reset (rst, synchronous, active high) clears config, counters, fill, drain state and output valid.
// ----------------------------------------------------------------------------
// byte_sequence_patcher_core
// Streaming byte sequence finder and patcher built on a chain of window cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_sequence_patcher_core_defines.svh"

module byte_sequence_patcher_core (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bsp_pkg::ByteW-1:0]      s_tdata,   // [7:0] data_byte
  input  logic [0:0]                     s_tuser,   // [0] cmd
  input  logic                           s_tlast,   // final_byte
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bsp_pkg::MDataW-1:0]     m_tdata,   // [7:0] out_byte, [28:8] place_count, rest 0
  output logic [0:0]                     m_tuser,   // [0] misfit
  output logic                           m_tlast,   // run_end
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsp_pkg::PaddrW-1:0]     paddr,
  input  logic [bsp_pkg::PdataW-1:0]     pwdata,
  output logic [bsp_pkg::PdataW-1:0]     prdata,
  output logic                           pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  bsp_pkg::cfg_t     cfg;
  bsp_pkg::reg_idx_t reg_sel;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = bsp_pkg::reg_idx_t'(paddr[bsp_pkg::PaddrW-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        bsp_pkg::REG_FIND_PATTERN: cfg.find_pattern <= pwdata;
        bsp_pkg::REG_MATCH_LEN:    cfg.match_len    <= pwdata[bsp_pkg::LenW-1:0];
        bsp_pkg::REG_PATCH_BYTES:  cfg.patch_bytes  <= pwdata;
        bsp_pkg::REG_PATCH_LENGTH: cfg.patch_length <= pwdata[bsp_pkg::LenW-1:0];
        bsp_pkg::REG_PATCH_OFFSET: cfg.patch_offset <= pwdata[bsp_pkg::OffW-1:0];
        bsp_pkg::REG_PLACE_LIMIT:  cfg.place_limit  <= pwdata[bsp_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bsp_pkg::REG_FIND_PATTERN: prdata = cfg.find_pattern;
      bsp_pkg::REG_MATCH_LEN:    prdata = bsp_pkg::PdataW'(cfg.match_len);
      bsp_pkg::REG_PATCH_BYTES:  prdata = cfg.patch_bytes;
      bsp_pkg::REG_PATCH_LENGTH: prdata = bsp_pkg::PdataW'(cfg.patch_length);
      bsp_pkg::REG_PATCH_OFFSET: prdata = bsp_pkg::PdataW'(cfg.patch_offset);
      bsp_pkg::REG_PLACE_LIMIT:  prdata = bsp_pkg::PdataW'(cfg.place_limit);
      default:                   prdata = '0;
    endcase
  end

  // Patch must sit inside the sequence; otherwise nothing is ever found.
  logic [bsp_pkg::LenW:0] patch_end;
  logic                   misfit;
  logic                   active;

  assign patch_end = (bsp_pkg::LenW + 1)'(cfg.patch_offset) + {1'b0, cfg.patch_length};
  assign misfit    = patch_end > {1'b0, cfg.match_len};
  assign active    = !misfit && (cfg.match_len != '0) &&
                     (cfg.match_len <= bsp_pkg::LenW'(bsp_pkg::WinBytes));

  // --------------------------------------------------------------------------
  // Handshake and window fill
  // --------------------------------------------------------------------------
  logic                       out_valid;
  logic                       load_ok;
  logic                       accept;
  logic                       flushing;
  logic [bsp_pkg::IdxW-1:0]   flush_idx;
  logic [bsp_pkg::CountW-1:0] flush_count;
  logic [bsp_pkg::IdxW-1:0]   fill;
  logic                       full;

  // Output register frees up when empty or taken this cycle.
  assign load_ok  = !out_valid || m_tready;
  assign s_tready = !flushing && load_ok;
  assign accept   = s_tvalid && s_tready;
  assign full     = (fill == bsp_pkg::IdxW'(bsp_pkg::WinBytes - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        fill <= '0;
      end else if (!full) begin
        fill <= fill + bsp_pkg::IdxW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: cell j sees the byte of age j once the new byte is in
  // --------------------------------------------------------------------------
  logic [bsp_pkg::ByteW-1:0] cell_in  [bsp_pkg::WinBytes];
  logic [bsp_pkg::ByteW-1:0] cell_fwd [bsp_pkg::WinBytes];
  logic [bsp_pkg::ByteW-1:0] cell_q   [bsp_pkg::WinBytes];
  logic [bsp_pkg::WinBytes-1:0] cell_match;
  bsp_pkg::tally_t           tally;
  bsp_pkg::step_t            step;
  logic                      hit;

  for (genvar j = 0; j < bsp_pkg::WinBytes; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cell_in[j] = s_tdata;
    end else begin : g_link
      assign cell_in[j] = cell_q[j-1];
    end

    bsp_cell u_cell (
      .clk      (clk),
      .age      (bsp_pkg::IdxW'(j)),
      .shift    (accept),
      .byte_in  (cell_in[j]),
      .cfg      (cfg),
      .patch_go (tally.patch_go),
      .match    (cell_match[j]),
      .byte_fwd (cell_fwd[j]),
      .byte_q   (cell_q[j])
    );
  end

  // Hit needs the whole sequence inside the window and no overlap in progress.
  assign hit = accept && active && tally.check_en && (&cell_match) &&
               ((bsp_pkg::LenW'(fill) + bsp_pkg::LenW'(1)) >= cfg.match_len);

  assign step.step = accept;
  assign step.cmd  = s_tuser[0];
  assign step.fin  = s_tlast;
  assign step.hit  = hit;

  bsp_tally u_tally (
    .clk         (clk),
    .rst         (rst),
    .ctl         (step),
    .match_len   (cfg.match_len),
    .place_limit (cfg.place_limit),
    .st          (tally)
  );

  // --------------------------------------------------------------------------
  // Drain after a final patch-pass byte: oldest first, count on the last
  // --------------------------------------------------------------------------
  logic flush_start;
  logic emit_norm;
  logic emit_cnt;
  logic emit_flush;

  assign flush_start = accept && s_tuser[0] && s_tlast;
  assign emit_norm   = accept && s_tuser[0] && !s_tlast && full;
  assign emit_cnt    = accept && !s_tuser[0] && s_tlast;
  assign emit_flush  = flushing && load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing <= 1'b0;
    end else if (flush_start) begin
      flushing <= 1'b1;
    end else if (emit_flush && (flush_idx == '0)) begin
      flushing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flush_start) begin
      flush_idx   <= fill;
      flush_count <= tally.report;
    end else if (emit_flush) begin
      flush_idx <= flush_idx - bsp_pkg::IdxW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [bsp_pkg::ByteW-1:0]  out_byte;
  logic [bsp_pkg::CountW-1:0] out_count;
  logic                       out_end;
  logic                       out_mis;
  logic                       out_load;

  assign out_load = emit_norm || emit_cnt || emit_flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_flush) begin
      out_byte  <= cell_q[flush_idx];
      out_end   <= (flush_idx == '0);
      out_count <= (flush_idx == '0) ? flush_count : '0;
      out_mis   <= misfit;
    end else if (emit_cnt) begin
      out_byte  <= '0;
      out_end   <= 1'b1;
      out_count <= tally.report;
      out_mis   <= misfit;
    end else if (emit_norm) begin
      out_byte  <= cell_fwd[bsp_pkg::WinBytes-1];
      out_end   <= 1'b0;
      out_count <= '0;
      out_mis   <= misfit;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = bsp_pkg::MDataW'({out_count, out_byte});
  assign m_tuser  = out_mis;
  assign m_tlast  = out_end;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BSP_ASSERT_IMP(a_count_only_at_end, m_tvalid && !m_tlast, out_count == '0,
                  "place count nonzero on a result that does not end a pass")
  `BSP_ASSERT_NXT(a_full_window_emits, emit_norm, m_tvalid && !m_tlast,
                  "full window did not hand its oldest byte to the output")
  `BSP_ASSERT_IMP(a_drain_cause, $rose(flushing),
                  $past(s_tvalid && s_tready && s_tlast && s_tuser[0]),
                  "window drain started without a final patch-pass byte")
  `BSP_ASSERT_NXT(a_drain_done, emit_flush && (flush_idx == '0), !flushing && m_tlast,
                  "last drained byte did not close the pass")

endmodule
